@@ src/two_level_page_walk_unit_defines.svh @@
// Assertion macros shared by the page walk unit modules.
`ifndef TWO_LEVEL_PAGE_WALK_UNIT_DEFINES_SVH
`define TWO_LEVEL_PAGE_WALK_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tpw_pkg.sv @@
// Types, constants and the microcode program of the page walk unit.
`default_nettype none

package tpw_pkg;

    localparam int NUM_PAGES_DEF = 128;
    localparam int PAGE_BYTES    = 32;
    localparam int OFF_W         = 5;
    localparam int FRAME_W       = 7;
    localparam int PAGE_SPAN     = 2 ** FRAME_W;
    localparam int ADDR_W        = 12;
    localparam int BYTE_W        = 8;
    localparam int VADDR_W       = 15;
    localparam int VA_TBL_LSB    = OFF_W;
    localparam int VA_DIR_LSB    = 2 * OFF_W;
    localparam int VALID_BIT     = 7;
    localparam logic [ADDR_W-1:0] DIR_BASE_RST = 12'h220;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_DIR_FAULT  = 2'd1,
        ST_TBL_FAULT  = 2'd2,
        ST_WRITE_DONE = 2'd3
    } t_status;

    // Input word, mem_addr in the lowest bits.
    typedef struct packed {
        logic [4:0]         pad;
        logic [VADDR_W-1:0] vaddr;
        logic [BYTE_W-1:0]  mem_data;
        logic [ADDR_W-1:0]  mem_addr;
    } t_in_word;

    // Result word, dir_index in the lowest bits.
    typedef struct packed {
        logic [1:0]         pad;
        logic [BYTE_W-1:0]  data_byte;
        logic [ADDR_W-1:0]  phys_addr;
        logic [FRAME_W-1:0] tbl_frame;
        logic               tbl_valid;
        logic [OFF_W-1:0]   tbl_index;
        logic [FRAME_W-1:0] dir_frame;
        logic               dir_valid;
        logic [OFF_W-1:0]   dir_index;
    } t_result;

    localparam int IN_W  = $bits(t_in_word);
    localparam int OUT_W = $bits(t_result);

    // Program steps.
    localparam int STEP_W = 2;
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step STEP_IDLE = 2'd0;
    localparam t_step STEP_TBL  = 2'd1;
    localparam t_step STEP_DATA = 2'd2;
    localparam t_step STEP_EMIT = 2'd3;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_WRITE,
        C_ENTRY_BAD,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [1:0] {
        M_NONE,
        M_IN,
        M_TBL,
        M_DATA
    } t_mem;

    typedef struct packed {
        logic  take_in;
        logic  cap_dir;
        logic  cap_tbl;
        logic  emit;
        t_mem  mem;
        t_cond hold;
        t_cond jump;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic in_write;
        logic entry_bad;
        logic out_busy;
    } t_flags;

    // Control store. A step stays while its hold condition is true, otherwise
    // it goes to target when its jump condition is true, else to the next step.
    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        w = '{take_in: 1'b0, cap_dir: 1'b0, cap_tbl: 1'b0, emit: 1'b0,
              mem: M_NONE, hold: C_NEVER, jump: C_NEVER, target: STEP_IDLE};
        unique case (step)
            STEP_IDLE: begin
                w.take_in = 1'b1;
                w.mem     = M_IN;
                w.hold    = C_NO_INPUT;
                w.jump    = C_WRITE;
                w.target  = STEP_EMIT;
            end
            STEP_TBL: begin
                w.cap_dir = 1'b1;
                w.mem     = M_TBL;
                w.jump    = C_ENTRY_BAD;
                w.target  = STEP_EMIT;
            end
            STEP_DATA: begin
                w.cap_tbl = 1'b1;
                w.mem     = M_DATA;
                w.jump    = C_ENTRY_BAD;
                w.target  = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.emit   = 1'b1;
                w.hold   = C_OUT_BUSY;
                w.jump   = C_ALWAYS;
                w.target = STEP_IDLE;
            end
            default: begin
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ src/tpw_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none

module tpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/tpw_seq.sv @@
// Microcode sequencer: step counter, control store and branch logic.
`default_nettype none
`include "two_level_page_walk_unit_defines.svh"

module tpw_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tpw_pkg::t_flags i_flags,
    output tpw_pkg::t_uword      o_uword
);
    import tpw_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_uw;

    function automatic logic cond_true(input t_cond c, input t_flags f);
        logic res;
        res = 1'b0;
        unique case (c)
            C_NEVER:     res = 1'b0;
            C_ALWAYS:    res = 1'b1;
            C_NO_INPUT:  res = !f.in_valid;
            C_WRITE:     res = f.in_write;
            C_ENTRY_BAD: res = f.entry_bad;
            C_OUT_BUSY:  res = f.out_busy;
            default:     res = 1'b0;
        endcase
        return res;
    endfunction

    assign w_uw = uc_rom(r_step);

    always_comb begin
        if (cond_true(w_uw.hold, i_flags)) begin
            n_step = r_step;
        end else if (cond_true(w_uw.jump, i_flags)) begin
            n_step = w_uw.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = w_uw;

    `TPW_ASSERT_NXT(a_write_goes_emit, i_clk, i_rst_n,
        r_step == STEP_IDLE && i_flags.in_valid && i_flags.in_write,
        r_step == STEP_EMIT, "write word did not go straight to emit")
    `TPW_ASSERT_IMP(a_data_after_tbl, i_clk, i_rst_n,
        r_step == STEP_DATA, $past(r_step) == STEP_TBL,
        "data step not preceded by table step")
    `TPW_ASSERT_NXT(a_emit_returns_idle, i_clk, i_rst_n,
        r_step == STEP_EMIT && !i_flags.out_busy,
        r_step == STEP_IDLE, "emit step did not return to idle")

endmodule

`default_nettype wire

@@ src/tpw_dp.sv @@
// Walk datapath: base register, entry registers, RAM addressing, output register.
`default_nettype none
`include "two_level_page_walk_unit_defines.svh"

module tpw_dp #(
    parameter int NUM_PAGES = tpw_pkg::NUM_PAGES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [tpw_pkg::ADDR_W-1:0]            i_cfg_wdata,
    input  wire tpw_pkg::t_uword                       i_uword,
    output tpw_pkg::t_flags                            o_flags,
    input  wire logic                                  i_in_valid,
    input  wire logic [tpw_pkg::IN_W-1:0]              i_in_data,
    input  wire logic                                  i_in_func,
    output logic                                       o_ram_en,
    output logic                                       o_ram_we,
    output logic [$clog2(NUM_PAGES)+tpw_pkg::OFF_W-1:0] o_ram_addr,
    output logic [tpw_pkg::BYTE_W-1:0]                 o_ram_wdata,
    input  wire logic [tpw_pkg::BYTE_W-1:0]            i_ram_rdata,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [tpw_pkg::OUT_W-1:0]                  o_out_data,
    output logic [1:0]                                 o_out_user
);
    import tpw_pkg::*;

    localparam int PW = $clog2(NUM_PAGES);

    logic [PW-1:0]      w_wrap [PAGE_SPAN];
    t_in_word           w_in;
    logic               w_accept;
    logic               w_load;
    logic               w_busy;
    t_result            w_res;

    logic [ADDR_W-1:0]  r_base;
    logic [VADDR_W-1:0] r_vaddr;
    t_status            r_status;
    logic [BYTE_W-1:0]  r_de;
    logic [BYTE_W-1:0]  r_te;
    logic               r_o_valid;
    t_result            r_o_res;
    t_status            r_o_user;

    // Page numbers wrap modulo the page count before they reach the RAM.
    for (genvar g = 0; g < PAGE_SPAN; g++) begin : g_wrap
        assign w_wrap[g] = PW'(g % NUM_PAGES);
    end

    assign w_in     = i_in_data;
    assign w_accept = i_uword.take_in && i_in_valid;
    assign w_busy   = r_o_valid && !i_out_ready;
    assign w_load   = i_uword.emit && !w_busy;

    assign o_flags.in_valid  = i_in_valid;
    assign o_flags.in_write  = !i_in_func;
    assign o_flags.entry_bad = !i_ram_rdata[VALID_BIT];
    assign o_flags.out_busy  = w_busy;

    always_comb begin
        o_ram_en   = 1'b0;
        o_ram_we   = 1'b0;
        o_ram_addr = '0;
        unique case (i_uword.mem)
            M_NONE: begin
            end
            M_IN: begin
                o_ram_en = w_accept;
                o_ram_we = w_accept && !i_in_func;
                if (i_in_func) begin
                    o_ram_addr = {w_wrap[r_base[ADDR_W-1:OFF_W]],
                                  w_in.vaddr[VA_DIR_LSB +: OFF_W]};
                end else begin
                    o_ram_addr = {w_wrap[w_in.mem_addr[ADDR_W-1:OFF_W]],
                                  w_in.mem_addr[OFF_W-1:0]};
                end
            end
            M_TBL: begin
                o_ram_en   = 1'b1;
                o_ram_addr = {w_wrap[i_ram_rdata[FRAME_W-1:0]],
                              r_vaddr[VA_TBL_LSB +: OFF_W]};
            end
            M_DATA: begin
                o_ram_en   = 1'b1;
                o_ram_addr = {w_wrap[i_ram_rdata[FRAME_W-1:0]], r_vaddr[OFF_W-1:0]};
            end
            default: begin
            end
        endcase
    end

    assign o_ram_wdata = w_in.mem_data;

    // On a good walk the data byte is still held in the RAM read register.
    always_comb begin
        w_res = '0;
        if (r_status != ST_WRITE_DONE) begin
            w_res.dir_index = r_vaddr[VA_DIR_LSB +: OFF_W];
            w_res.dir_valid = r_de[VALID_BIT];
            w_res.dir_frame = r_de[FRAME_W-1:0];
            w_res.tbl_index = r_vaddr[VA_TBL_LSB +: OFF_W];
        end
        if (r_status == ST_OK || r_status == ST_TBL_FAULT) begin
            w_res.tbl_valid = r_te[VALID_BIT];
            w_res.tbl_frame = r_te[FRAME_W-1:0];
        end
        if (r_status == ST_OK) begin
            w_res.phys_addr = {r_te[FRAME_W-1:0], r_vaddr[OFF_W-1:0]};
            w_res.data_byte = i_ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= DIR_BASE_RST;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vaddr  <= w_in.vaddr;
            r_status <= i_in_func ? ST_OK : ST_WRITE_DONE;
        end
        if (i_uword.cap_dir) begin
            r_de <= i_ram_rdata;
            if (!i_ram_rdata[VALID_BIT]) begin
                r_status <= ST_DIR_FAULT;
            end
        end
        if (i_uword.cap_tbl) begin
            r_te <= i_ram_rdata;
            if (!i_ram_rdata[VALID_BIT]) begin
                r_status <= ST_TBL_FAULT;
            end
        end
        if (w_load) begin
            r_o_res  <= w_res;
            r_o_user <= r_status;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_res;
    assign o_out_user  = r_o_user;

    `TPW_ASSERT_IMP(a_dir_fault_no_tbl, i_clk, i_rst_n,
        r_o_valid && r_o_user == ST_DIR_FAULT,
        !r_o_res.tbl_valid && r_o_res.phys_addr == '0 && r_o_res.data_byte == '0,
        "directory fault reports table fields")
    `TPW_ASSERT_NXT(a_phys_offset, i_clk, i_rst_n,
        w_load && r_status == ST_OK,
        r_o_res.phys_addr[OFF_W-1:0] == $past(r_vaddr[OFF_W-1:0]),
        "physical address offset differs from virtual offset")

endmodule

`default_nettype wire

@@ src/two_level_page_walk_unit.sv @@
// Two-level page walk unit: top level over sequencer, datapath and page RAM.
//
// Input words arrive on s_axis: tuser[0] is func (0 writes one memory byte,
// 1 translates), tdata carries mem_addr, mem_data and vaddr. Each input word
// yields exactly one result word on m_axis: tuser carries the status, tdata
// the walk fields. The directory base register is written through i_cfg_we
// and i_cfg_wdata; the user must write it only while the unit is idle, as
// the unit itself does not enforce this. A write word goes from acceptance
// straight to the emit step, a translation walks the table and data steps
// first (the data step is skipped on a directory fault): the walk makes up
// to three dependent reads of the single-port page RAM (directory entry,
// table entry, data byte), and the data byte goes straight into the output
// register. One word is in the walk at a time; the next one is accepted the
// cycle after the previous result is loaded.
// A finished result waits in the output register while m_axis_tready is low;
// the unit still takes and walks one more word, then holds its last step
// and takes no new word until the register is free.
// Reset clears the control state and sets the directory base to 0x220. The
// page RAM is not cleared; entries must be written before a walk reads them.
`default_nettype none

module two_level_page_walk_unit #(
    parameter int NUM_PAGES = tpw_pkg::NUM_PAGES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [tpw_pkg::ADDR_W-1:0]   i_cfg_wdata,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // mem_addr[11:0], mem_data[19:12], vaddr[34:20], zero fill
    input  wire logic [tpw_pkg::IN_W-1:0]     s_axis_tdata,
    // func[0]
    input  wire logic                         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // dir_index[4:0], dir_valid[5], dir_frame[12:6], tbl_index[17:13],
    // tbl_valid[18], tbl_frame[25:19], phys_addr[37:26], data_byte[45:38],
    // zero fill
    output logic [tpw_pkg::OUT_W-1:0]         m_axis_tdata,
    // status[1:0]
    output logic [1:0]                        m_axis_tuser
);
    import tpw_pkg::*;

    localparam int RAM_AW    = $clog2(NUM_PAGES) + OFF_W;
    localparam int RAM_DEPTH = NUM_PAGES * PAGE_BYTES;

    t_uword              w_uword;
    t_flags              w_flags;
    logic                w_ram_en;
    logic                w_ram_we;
    logic [RAM_AW-1:0]   w_ram_addr;
    logic [BYTE_W-1:0]   w_ram_wdata;
    logic [BYTE_W-1:0]   w_ram_rdata;

    tpw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uword)
    );

    tpw_dp #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_uword     (w_uword),
        .o_flags     (w_flags),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata),
        .i_in_func   (s_axis_tuser),
        .o_ram_en    (w_ram_en),
        .o_ram_we    (w_ram_we),
        .o_ram_addr  (w_ram_addr),
        .o_ram_wdata (w_ram_wdata),
        .i_ram_rdata (w_ram_rdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

    tpw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign s_axis_tready = w_uword.take_in;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the two-level page walk unit: directed table, then random walks.
`timescale 1ns / 1ps

module tb_top;
    import tpw_pkg::*;

    localparam int PAGES        = NUM_PAGES_DEF;
    localparam int RAM_BYTES    = PAGES * PAGE_BYTES;
    localparam int N_PHASES     = 5;
    localparam int PHASE_WORDS  = 120;
    localparam int CALM_WORDS   = 60;
    localparam int SETTLE       = 6;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        t_status status;
        t_result res;
    } t_walk_word;

    typedef struct {
        bit                 func;
        logic [ADDR_W-1:0]  addr;
        logic [BYTE_W-1:0]  data;
        logic [VADDR_W-1:0] vaddr;
        bit                 typed;
        t_walk_word         want;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [ADDR_W-1:0] i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [1:0]        m_axis_tuser;

    // Shadow of the page RAM, the directory base and the walks still owed.
    logic [BYTE_W-1:0] page_ram [RAM_BYTES];
    bit                page_ram_set [RAM_BYTES];
    logic [ADDR_W-1:0] dir_base = DIR_BASE_RST;
    t_walk_word        walk_due_q [$];
    t_stim_row         directed_rows [$];

    int  error_count   = 0;
    int  results_seen  = 0;
    int  words_sent    = 0;
    int  calm_after    = 1 << 30;
    int  tx_gap_pct    = 30;
    int  cycle_count   = 0;
    int  rx_stall      = 0;
    int  rx_quiet      = 0;
    bit  calm          = 1'b0;
    logic [VADDR_W-1:0] last_va = '0;

    two_level_page_walk_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // mem_addr[11:0], mem_data[19:12], vaddr[34:20], zero fill
        .s_axis_tdata  (s_axis_tdata),
        // func[0]
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // dir_index[4:0], dir_valid[5], dir_frame[12:6], tbl_index[17:13],
        // tbl_valid[18], tbl_frame[25:19], phys_addr[37:26], data_byte[45:38], zero fill
        .m_axis_tdata  (m_axis_tdata),
        // status[1:0]
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic int ram_addr(input logic [FRAME_W-1:0] page,
                                    input logic [OFF_W-1:0] off);
        return (int'(page) % PAGES) * PAGE_BYTES + int'(off);
    endfunction

    // Applies one word to the shadow state and returns the walk it should produce.
    function automatic t_walk_word predict_walk(input bit f, input logic [ADDR_W-1:0] a,
                                                input logic [BYTE_W-1:0] d,
                                                input logic [VADDR_W-1:0] v);
        t_walk_word e;
        logic [BYTE_W-1:0] ent;
        int idx;
        e = '0;
        if (!f) begin
            idx = ram_addr(a[11:5], a[4:0]);
            page_ram[idx] = d;
            page_ram_set[idx] = 1'b1;
            e.status = ST_WRITE_DONE;
            return e;
        end
        e.res.dir_index = v[14:10];
        e.res.tbl_index = v[9:5];
        ent = page_ram[ram_addr(dir_base[11:5], v[14:10])];
        e.res.dir_valid = ent[VALID_BIT];
        e.res.dir_frame = ent[FRAME_W-1:0];
        if (!ent[VALID_BIT]) begin
            e.status = ST_DIR_FAULT;
            return e;
        end
        ent = page_ram[ram_addr(ent[FRAME_W-1:0], v[9:5])];
        e.res.tbl_valid = ent[VALID_BIT];
        e.res.tbl_frame = ent[FRAME_W-1:0];
        if (!ent[VALID_BIT]) begin
            e.status = ST_TBL_FAULT;
            return e;
        end
        e.res.phys_addr = {ent[FRAME_W-1:0], v[4:0]};
        e.res.data_byte = page_ram[ram_addr(ent[FRAME_W-1:0], v[4:0])];
        e.status = ST_OK;
        return e;
    endfunction

    // First byte on the walk of v that was never written, or -1 if the walk is safe.
    function automatic int next_unset_on_walk(input logic [VADDR_W-1:0] v,
                                              output bit is_entry);
        int a;
        logic [BYTE_W-1:0] ent;
        is_entry = 1'b1;
        a = ram_addr(dir_base[11:5], v[14:10]);
        if (!page_ram_set[a]) return a;
        ent = page_ram[a];
        if (!ent[VALID_BIT]) return -1;
        a = ram_addr(ent[FRAME_W-1:0], v[9:5]);
        if (!page_ram_set[a]) return a;
        ent = page_ram[a];
        if (!ent[VALID_BIT]) return -1;
        is_entry = 1'b0;
        a = ram_addr(ent[FRAME_W-1:0], v[4:0]);
        if (!page_ram_set[a]) return a;
        return -1;
    endfunction

    function automatic t_walk_word mk_walk(input t_status st, input logic [4:0] di,
                                           input bit dv, input logic [6:0] df,
                                           input logic [4:0] ti, input bit tv,
                                           input logic [6:0] tf, input logic [11:0] pa,
                                           input logic [7:0] db);
        t_walk_word e;
        e = '0;
        e.status = st;
        e.res.dir_index = di;
        e.res.dir_valid = dv;
        e.res.dir_frame = df;
        e.res.tbl_index = ti;
        e.res.tbl_valid = tv;
        e.res.tbl_frame = tf;
        e.res.phys_addr = pa;
        e.res.data_byte = db;
        return e;
    endfunction

    task automatic add_row(input bit f, input logic [ADDR_W-1:0] a,
                           input logic [BYTE_W-1:0] d, input logic [VADDR_W-1:0] v,
                           input bit typed, input t_walk_word want);
        t_stim_row r;
        r.func = f;
        r.addr = a;
        r.data = d;
        r.vaddr = v;
        r.typed = typed;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    task automatic log_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Sends one word, waits for the handshake and books the walk it owes.
    task automatic send_word(input bit f, input logic [ADDR_W-1:0] a,
                             input logic [BYTE_W-1:0] d, input logic [VADDR_W-1:0] v,
                             input bit typed, input t_walk_word want);
        t_in_word w;
        t_walk_word p;
        int gap;
        calm = (words_sent >= calm_after);
        if (!calm && $urandom_range(1, 100) <= tx_gap_pct) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w = '0;
        w.mem_addr = a;
        w.mem_data = d;
        w.vaddr = v;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        s_axis_tuser <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        p = predict_walk(f, a, d, v);
        walk_due_q.push_back(typed ? want : p);
        words_sent++;
    endtask

    task automatic drain_walks();
        s_axis_tvalid <= 1'b0;
        while (walk_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_dir_base(input logic [ADDR_W-1:0] value);
        drain_walks();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dir_base = value;
    endtask

    // One random scenario: a noise write, a random directory entry, or a walk whose
    // missing entries are filled in first so that every byte it reads is defined.
    task automatic run_scenario();
        int sel;
        int a;
        bit is_entry;
        logic [VADDR_W-1:0] va;
        logic [BYTE_W-1:0] val;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            send_word(1'b0, 12'($urandom_range(0, RAM_BYTES - 1)),
                      8'($urandom_range(0, 255)), 15'($urandom_range(0, 32767)),
                      1'b0, '0);
        end else if (sel < 20) begin
            send_word(1'b0, 12'(ram_addr(dir_base[11:5], last_va[14:10])),
                      8'($urandom_range(0, 255)), 15'($urandom_range(0, 32767)),
                      1'b0, '0);
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                va = {last_va[14:5], 5'($urandom_range(0, 31))};
            else if (sel < 55)
                va = {last_va[14:10], 10'($urandom_range(0, 1023))};
            else
                va = 15'($urandom_range(0, 32767));
            a = next_unset_on_walk(va, is_entry);
            while (a >= 0) begin
                if (is_entry)
                    val = {($urandom_range(0, 99) < 85) ? 1'b1 : 1'b0,
                           7'($urandom_range(0, 127))};
                else
                    val = 8'($urandom_range(0, 255));
                send_word(1'b0, 12'(a), val, 15'($urandom_range(0, 32767)), 1'b0, '0);
                a = next_unset_on_walk(va, is_entry);
            end
            send_word(1'b1, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                      va, 1'b0, '0);
            last_va = va;
        end
    endtask

    initial begin : stimulus
        t_walk_word write_done;
        logic [ADDR_W-1:0] base;
        int phase;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_done = mk_walk(ST_WRITE_DONE, 0, 0, 0, 0, 0, 0, 0, 0);
        // Directory entry 0 invalid, then a directory fault at address zero.
        add_row(1'b0, 12'h220, 8'h00, 15'h0000, 1'b1, write_done);
        add_row(1'b1, 12'h000, 8'h00, 15'h0000, 1'b1,
                mk_walk(ST_DIR_FAULT, 0, 0, 0, 0, 0, 0, 0, 0));
        // Last directory entry points at the last page, whose last entry is invalid.
        add_row(1'b0, 12'h23f, 8'hff, 15'h0000, 1'b1, write_done);
        add_row(1'b0, 12'hfff, 8'h7f, 15'h0000, 1'b1, write_done);
        add_row(1'b1, 12'h000, 8'h00, 15'h7fff, 1'b1,
                mk_walk(ST_TBL_FAULT, 31, 1, 127, 31, 0, 127, 0, 0));
        add_row(1'b0, 12'hfff, 8'h80, 15'h0000, 1'b0, '0);
        add_row(1'b0, 12'h01f, 8'hff, 15'h0000, 1'b0, '0);
        add_row(1'b1, 12'h000, 8'h00, 15'h7fff, 1'b0, '0);
        // The table entry is also the data byte at the top of memory.
        add_row(1'b0, 12'hfff, 8'hff, 15'h0000, 1'b0, '0);
        add_row(1'b1, 12'h000, 8'h00, 15'h7fff, 1'b1,
                mk_walk(ST_OK, 31, 1, 127, 31, 1, 127, 12'hfff, 8'hff));
        // Table entry and data byte both at address zero of page zero.
        add_row(1'b0, 12'h220, 8'h80, 15'h0000, 1'b0, '0);
        add_row(1'b0, 12'h000, 8'h80, 15'h0000, 1'b0, '0);
        add_row(1'b1, 12'h000, 8'h00, 15'h0000, 1'b1,
                mk_walk(ST_OK, 0, 1, 0, 0, 1, 0, 12'h000, 8'h80));
        // Invalid directory entry that still carries a frame.
        add_row(1'b0, 12'h23f, 8'h7f, 15'h0000, 1'b0, '0);
        add_row(1'b1, 12'hfff, 8'hff, 15'h7fe0, 1'b0, '0);
        // Table fault in the middle of the map.
        add_row(1'b0, 12'h221, 8'h85, 15'h0000, 1'b0, '0);
        add_row(1'b0, 12'h0a2, 8'h03, 15'h0000, 1'b0, '0);
        add_row(1'b1, 12'h000, 8'h00, 15'h0447, 1'b0, '0);

        foreach (directed_rows[i])
            send_word(directed_rows[i].func, directed_rows[i].addr, directed_rows[i].data,
                      directed_rows[i].vaddr, directed_rows[i].typed, directed_rows[i].want);

        calm_after = words_sent + N_PHASES * PHASE_WORDS - CALM_WORDS;
        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: base = 12'h000;
                1: base = 12'hfff;
                2: base = 12'h5a3;
                default: base = 12'($urandom_range(0, 4095));
            endcase
            write_dir_base(base);
            tx_gap_pct = (phase == 1) ? 0 : $urandom_range(10, 40);
            while (words_sent < directed_rows.size() + (phase + 1) * PHASE_WORDS)
                run_scenario();
        end

        s_axis_tvalid <= 1'b0;
        while (walk_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin : sink_pacing
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else if (rx_quiet > 0) begin
            rx_quiet--;
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            rx_stall = $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 49) == 0)
                rx_quiet = $urandom_range(40, 160);
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_walk_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            results_seen++;
            if (walk_due_q.size() == 0) begin
                log_mismatch("result word with no walk pending");
            end else begin
                want = walk_due_q.pop_front();
                compare_field("status", 32'(m_axis_tuser), 32'(want.status));
                compare_field("dir_index", 32'(got.dir_index), 32'(want.res.dir_index));
                compare_field("dir_valid", 32'(got.dir_valid), 32'(want.res.dir_valid));
                compare_field("dir_frame", 32'(got.dir_frame), 32'(want.res.dir_frame));
                compare_field("tbl_index", 32'(got.tbl_index), 32'(want.res.tbl_index));
                compare_field("tbl_valid", 32'(got.tbl_valid), 32'(want.res.tbl_valid));
                compare_field("tbl_frame", 32'(got.tbl_frame), 32'(want.res.tbl_frame));
                compare_field("phys_addr", 32'(got.phys_addr), 32'(want.res.phys_addr));
                compare_field("data_byte", 32'(got.data_byte), 32'(want.res.data_byte));
                compare_field("zero fill", 32'(got.pad), 32'd0);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout with %0d walks pending", walk_due_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
